### hw/rtl/cisa_pkg.sv
`timescale 1ns / 1ps
package cisa_pkg;

	localparam int unsigned DataW      = 32;
	localparam int unsigned DivSteps   = 32;
	localparam int unsigned QueueDepth = 4;
	localparam logic [4:0]  SHIFT_MASK = 5'h1F;

	typedef enum logic [4:0] {
		F_LNOT = 5'd0,
		F_BNOT = 5'd1,
		F_NEG  = 5'd2,
		F_INC  = 5'd3,
		F_DEC  = 5'd4,
		F_ADD  = 5'd5,
		F_SUB  = 5'd6,
		F_MUL  = 5'd7,
		F_DIV  = 5'd8,
		F_REM  = 5'd9,
		F_SHL  = 5'd10,
		F_SAR  = 5'd11,
		F_SHR  = 5'd12,
		F_AND  = 5'd13,
		F_OR   = 5'd14,
		F_XOR  = 5'd15,
		F_EQ   = 5'd16,
		F_NE   = 5'd17,
		F_LT   = 5'd18,
		F_LE   = 5'd19,
		F_GT   = 5'd20,
		F_GE   = 5'd21
	} func_t;

	typedef enum logic [1:0] {
		K_INT     = 2'd0,
		K_BOOL    = 2'd1,
		K_INVALID = 2'd2
	} kind_t;

	// classified item as held in the queue
	typedef struct packed {
		func_t              func;
		logic               div_zero;
		logic               neg_a;
		logic               neg_b;
		logic [DataW-1:0]   a;
		logic [DataW-1:0]   b;
	} op_t;

endpackage

### hw/rtl/checked_int32_script_alu_core.sv
`timescale 1ns / 1ps
// Overflow-checked 32-bit integer ALU for a script interpreter.
// Input channel: in_valid / in_stall with func, operand_a, operand_b.
// Output channel: out_valid / out_stall with result_value, result_kind
// (0 integer, 1 boolean, 2 invalid; value is 0 when invalid).
// An item is taken on a rising edge with valid high and stall low.
// Throughput: one item per cycle while out_stall is low. Each accepted item
// passes the queue, a first-stage register, the 32 one-bit stages of the
// pipelined divider and the output register, so results leave in order.
// A small queue sits between input and execution; in_stall rises only when
// it is full. When out_valid and out_stall are high the result holds and
// the execution pipe freezes; the queue keeps taking items until it fills.
// Reset (arst_n low) empties the queue and clears every valid bit; no
// clearing pass is needed afterwards.
module checked_int32_script_alu_core #(
	parameter int unsigned QUEUE_DEPTH = cisa_pkg::QueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [4:0]          func,
	input  logic signed [31:0]  operand_a,
	input  logic signed [31:0]  operand_b,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  result_value,
	output logic [1:0]          result_kind
);
	import cisa_pkg::*;

	op_t  front_op, queue_op;
	logic q_empty, q_full, take;

	assign in_stall = q_full;

	cisa_front u_front (
		.func      (func),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.op        (front_op)
	);

	cisa_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_valid && !q_full),
		.wdata  (front_op),
		.pop    (take),
		.rdata  (queue_op),
		.empty  (q_empty),
		.full   (q_full)
	);

	cisa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_op        (queue_op),
		.in_avail     (!q_empty),
		.in_take      (take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.result_kind  (result_kind)
	);

endmodule

### hw/rtl/cisa_front.sv
`timescale 1ns / 1ps
module cisa_front (
	input  logic [4:0]          func,
	input  logic signed [31:0]  operand_a,
	input  logic signed [31:0]  operand_b,
	output cisa_pkg::op_t       op
);
	import cisa_pkg::*;

	always_comb begin
		op.func     = func_t'(func);
		op.a        = operand_a;
		op.b        = operand_b;
		op.neg_a    = operand_a[DataW-1];
		op.neg_b    = operand_b[DataW-1];
		op.div_zero = (operand_b == '0);
	end

endmodule

### hw/rtl/cisa_queue.sv
`timescale 1ns / 1ps
module cisa_queue #(
	parameter int unsigned DEPTH = cisa_pkg::QueueDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cisa_pkg::op_t  wdata,
	input  logic           pop,
	output cisa_pkg::op_t  rdata,
	output logic           empty,
	output logic           full
);
	import cisa_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	op_t             mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == FullCnt);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/cisa_back.sv
`timescale 1ns / 1ps
module cisa_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cisa_pkg::op_t       in_op,
	input  logic                in_avail,
	output logic                in_take,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  result_value,
	output logic [1:0]          result_kind
);
	import cisa_pkg::*;

	typedef struct packed {
		logic [DataW-1:0] value;
		kind_t            kind;
	} res_t;

	typedef struct packed {
		func_t            func;
		logic             div_zero;
		logic             neg_q;
		logic             neg_r;
		res_t             res;
		logic [DataW-1:0] rem;
		logic [DataW-1:0] quo;
		logic [DataW-1:0] dvs;
	} dstage_t;

	function automatic res_t check33(input logic [DataW:0] s);
		res_t r;
		if (s[DataW] != s[DataW-1]) begin
			r.value = '0;
			r.kind  = K_INVALID;
		end else begin
			r.value = s[DataW-1:0];
			r.kind  = K_INT;
		end
		return r;
	endfunction

	function automatic res_t boolres(input logic b);
		res_t r;
		r.value = {{(DataW-1){1'b0}}, b};
		r.kind  = K_BOOL;
		return r;
	endfunction

	function automatic res_t intres(input logic [DataW-1:0] v);
		res_t r;
		r.value = v;
		r.kind  = K_INT;
		return r;
	endfunction

	function automatic dstage_t div_step(input dstage_t s);
		dstage_t         n;
		logic [DataW:0]  rr;
		logic [DataW:0]  diff;
		n    = s;
		rr   = {s.rem, s.quo[DataW-1]};
		diff = rr - {1'b0, s.dvs};
		if (!diff[DataW]) begin
			n.rem = diff[DataW-1:0];
			n.quo = {s.quo[DataW-2:0], 1'b1};
		end else begin
			n.rem = rr[DataW-1:0];
			n.quo = {s.quo[DataW-2:0], 1'b0};
		end
		return n;
	endfunction

	logic en;
	logic valid_s1;
	op_t  op_s1;
	res_t simple_s1;
	logic signed [2*DataW-1:0] prod_s1;

	logic valid_q [DivSteps];
	dstage_t pipe_q [DivSteps];
	dstage_t stage_in [DivSteps];

	logic out_valid_q;
	res_t out_q;

	// the whole back end moves only when the output slot is free or being drained
	assign en        = !out_valid_q || !out_stall;
	assign in_take   = en && in_avail;
	assign out_valid = out_valid_q;
	assign result_value = out_q.value;
	assign result_kind  = out_q.kind;

	// simple operations
	res_t            simple_c;
	logic [4:0]      sh;
	logic signed [DataW-1:0] sa, sb;
	always_comb begin
		sa = in_op.a;
		sb = in_op.b;
		sh = in_op.b[4:0] & SHIFT_MASK;
		case (in_op.func)
			F_LNOT:  simple_c = boolres(in_op.a == '0);
			F_BNOT:  simple_c = intres(~in_op.a);
			F_NEG:   simple_c = intres('0 - in_op.a);
			F_INC:   simple_c = check33({in_op.neg_a, in_op.a} + 33'd1);
			F_DEC:   simple_c = check33({in_op.neg_a, in_op.a} - 33'd1);
			F_ADD:   simple_c = check33({in_op.neg_a, in_op.a} + {in_op.neg_b, in_op.b});
			F_SUB:   simple_c = check33({in_op.neg_a, in_op.a} - {in_op.neg_b, in_op.b});
			F_MUL:   simple_c = intres('0);
			F_DIV:   simple_c = intres('0);
			F_REM:   simple_c = intres('0);
			F_SHL:   simple_c = intres(in_op.a << sh);
			F_SAR:   simple_c = intres(sa >>> sh);
			F_SHR:   simple_c = intres(in_op.a >> sh);
			F_AND:   simple_c = intres(in_op.a & in_op.b);
			F_OR:    simple_c = intres(in_op.a | in_op.b);
			F_XOR:   simple_c = intres(in_op.a ^ in_op.b);
			F_EQ:    simple_c = boolres(sa == sb);
			F_NE:    simple_c = boolres(sa != sb);
			F_LT:    simple_c = boolres(sa < sb);
			F_LE:    simple_c = boolres(sa <= sb);
			F_GT:    simple_c = boolres(sa > sb);
			F_GE:    simple_c = boolres(sa >= sb);
			default: begin
				simple_c.value = '0;
				simple_c.kind  = K_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1     <= in_op;
			simple_s1 <= simple_c;
			prod_s1   <= (2*DataW)'(sa) * (2*DataW)'(sb);
		end
	end

	// head of the divide chain: magnitudes, signs, checked product
	always_comb begin
		stage_in[0].func     = op_s1.func;
		stage_in[0].div_zero = op_s1.div_zero;
		stage_in[0].neg_q    = op_s1.neg_a ^ op_s1.neg_b;
		stage_in[0].neg_r    = op_s1.neg_a;
		stage_in[0].rem      = '0;
		stage_in[0].quo      = op_s1.neg_a ? ('0 - op_s1.a) : op_s1.a;
		stage_in[0].dvs      = op_s1.neg_b ? ('0 - op_s1.b) : op_s1.b;
		if (op_s1.func == F_MUL) begin
			if (prod_s1[2*DataW-1:DataW-1] == '0 || prod_s1[2*DataW-1:DataW-1] == '1) begin
				stage_in[0].res = intres(prod_s1[DataW-1:0]);
			end else begin
				stage_in[0].res.value = '0;
				stage_in[0].res.kind  = K_INVALID;
			end
		end else begin
			stage_in[0].res = simple_s1;
		end
	end

	for (genvar k = 1; k < DivSteps; k++) begin : g_link
		assign stage_in[k] = pipe_q[k-1];
	end

	for (genvar k = 0; k < DivSteps; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				pipe_q[k] <= div_step(stage_in[k]);
			end
		end
	end

	// finish the divide and remainder
	res_t            final_c;
	dstage_t         last;
	always_comb begin
		last = pipe_q[DivSteps-1];
		case (last.func)
			F_DIV: begin
				if (last.div_zero) begin
					final_c.value = '0;
					final_c.kind  = K_INVALID;
				end else begin
					final_c = check33(last.neg_q ? (33'd0 - {1'b0, last.quo})
					                             : {1'b0, last.quo});
				end
			end
			F_REM: begin
				if (last.div_zero) begin
					final_c.value = '0;
					final_c.kind  = K_INVALID;
				end else begin
					final_c = intres(last.neg_r ? ('0 - last.rem) : last.rem);
				end
			end
			default: final_c = last.res;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= final_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DivSteps; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (en) begin
			valid_s1   <= in_take;
			valid_q[0] <= valid_s1;
			for (int i = 1; i < DivSteps; i++) begin
				valid_q[i] <= valid_q[i-1];
			end
			out_valid_q <= valid_q[DivSteps-1];
		end
	end

endmodule
